### src/vgarq_pkg.sv
package vgarq_pkg;

    localparam int PEN_COUNT = 17;

    localparam logic [4:0] BORDER_PEN      = 5'd16;
    localparam logic [5:0] RASTER_INT_LINE = 6'd52;
    localparam logic [5:0] RESYNC_MARGIN   = 6'd32;
    localparam logic [1:0] RESYNC_LINES    = 2'd2;
    localparam logic [1:0] MODE_RESET      = 2'd1;
    localparam logic [1:0] PORT_SELECT     = 2'b01;

    // Function code in data bits 7:6 of a port write
    typedef enum logic [1:0] {
        FN_PEN  = 2'd0,
        FN_INK  = 2'd1,
        FN_MODE = 2'd2,
        FN_RAM  = 2'd3
    } port_fn_t;

    typedef struct packed {
        logic        hsync_level;
        logic        vsync_level;
        logic        cpu_m1;
        logic        cpu_iorq;
        logic        cpu_wr;
        logic [15:0] cpu_address;
        logic [7:0]  cpu_data;
        logic        companion_unlocked;
        logic        companion_irq_active;
        logic [4:0]  query_pen;
    } in_beat_t;

    typedef struct packed {
        logic       irq_out;
        logic [1:0] active_mode;
        logic [7:0] rom_setting;
        logic [7:0] ram_setting;
        logic [3:0] phase_out;
        logic [5:0] line_count_out;
        logic [4:0] query_colour;
    } out_beat_t;

endpackage

### src/vgarq_in_reg.sv
module vgarq_in_reg
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vgarq_pkg::in_beat_t in_beat,
    output logic               beat_valid,
    output vgarq_pkg::in_beat_t beat,
    input  logic               beat_take
);

    logic                valid_reg;
    logic                valid_next;
    vgarq_pkg::in_beat_t beat_reg;

    assign in_ready   = !valid_reg || beat_take;
    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (beat_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg <= in_beat;
        end
    end

endmodule

### src/vgarq_core.sv
module vgarq_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 beat_valid,
    input  vgarq_pkg::in_beat_t  beat,
    output logic                 beat_take,
    output logic                 res_valid,
    input  logic                 res_ready,
    output vgarq_pkg::out_beat_t res
);

    logic                 plus_reg;
    logic [3:0]           phase_reg;
    logic [3:0]           phase_next;
    logic [5:0]           line_reg;
    logic [5:0]           line_next;
    logic [1:0]           resync_reg;
    logic [1:0]           resync_next;
    logic                 hs_last_reg;
    logic                 vs_last_reg;
    logic                 irq_reg;
    logic                 irq_next;
    logic [4:0]           pen_reg;
    logic [4:0]           pen_next;
    logic [1:0]           cur_mode_reg;
    logic [1:0]           cur_mode_next;
    logic [1:0]           want_mode_reg;
    logic [1:0]           want_mode_next;
    logic [7:0]           rom_reg;
    logic [7:0]           rom_next;
    logic [7:0]           ram_reg;
    logic [7:0]           ram_next;
    logic [4:0]           ink_reg  [vgarq_pkg::PEN_COUNT];
    logic [4:0]           ink_next [vgarq_pkg::PEN_COUNT];
    logic                 res_valid_reg;
    logic                 res_valid_next;
    vgarq_pkg::out_beat_t res_reg;
    vgarq_pkg::out_beat_t res_next;

    logic                 hs_rise;
    logic                 hs_fall;
    logic                 vs_rise;
    logic                 owns;
    logic                 port_hit;
    logic                 ink_we;
    logic [5:0]           line_inc;
    logic [1:0]           resync_arm;
    vgarq_pkg::port_fn_t  fn;

    assign beat_take = beat_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign hs_rise  = beat.hsync_level && !hs_last_reg;
    assign hs_fall  = !beat.hsync_level && hs_last_reg;
    assign vs_rise  = beat.vsync_level && !vs_last_reg;
    assign owns     = !(plus_reg && beat.companion_irq_active);
    assign port_hit = beat.cpu_iorq && beat.cpu_wr
                      && (beat.cpu_address[15:14] == vgarq_pkg::PORT_SELECT);
    assign fn       = vgarq_pkg::port_fn_t'(beat.cpu_data[7:6]);
    assign line_inc = line_reg + 6'd1;

    always_comb
    begin
        phase_next     = phase_reg + 4'd1;
        cur_mode_next  = hs_rise ? want_mode_reg : cur_mode_reg;
        resync_arm     = vs_rise ? vgarq_pkg::RESYNC_LINES : resync_reg;
        resync_next    = resync_arm;
        line_next      = line_reg;
        irq_next       = irq_reg;
        pen_next       = pen_reg;
        want_mode_next = want_mode_reg;
        rom_next       = rom_reg;
        ram_next       = ram_reg;
        ink_we         = 1'b0;

        if (hs_fall)
        begin
            line_next = line_inc;
            if (line_inc == vgarq_pkg::RASTER_INT_LINE)
            begin
                if (owns)
                begin
                    irq_next = 1'b1;
                end
                line_next = '0;
            end
            if (resync_arm != 2'd0)
            begin
                resync_next = resync_arm - 2'd1;
                if (resync_next == 2'd0)
                begin
                    if (line_next >= vgarq_pkg::RESYNC_MARGIN && owns)
                    begin
                        irq_next = 1'b1;
                    end
                    line_next = '0;
                end
            end
        end

        // acknowledge lands before any port write in the same tick
        if (beat.cpu_m1 && beat.cpu_iorq)
        begin
            line_next = {1'b0, line_next[4:0]};
            irq_next  = 1'b0;
        end

        if (port_hit)
        begin
            unique case (fn)
                vgarq_pkg::FN_PEN:
                begin
                    pen_next = beat.cpu_data[4] ? vgarq_pkg::BORDER_PEN
                                                : {1'b0, beat.cpu_data[3:0]};
                end
                vgarq_pkg::FN_INK:
                begin
                    ink_we = (pen_reg <= vgarq_pkg::BORDER_PEN);
                end
                vgarq_pkg::FN_MODE:
                begin
                    // remap form belongs to the companion chip
                    if (!(plus_reg && beat.companion_unlocked && beat.cpu_data[5]))
                    begin
                        want_mode_next = beat.cpu_data[1:0];
                        rom_next       = beat.cpu_data;
                        if (beat.cpu_data[4])
                        begin
                            irq_next  = 1'b0;
                            line_next = '0;
                        end
                    end
                end
                vgarq_pkg::FN_RAM:
                begin
                    ram_next = beat.cpu_data;
                end
                default:
                begin
                    ram_next = ram_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < vgarq_pkg::PEN_COUNT; i++)
        begin
            ink_next[i] = (ink_we && (pen_reg == 5'(i))) ? beat.cpu_data[4:0] : ink_reg[i];
        end
    end

    always_comb
    begin
        res_next.irq_out        = irq_next;
        res_next.active_mode    = cur_mode_next;
        res_next.rom_setting    = rom_next;
        res_next.ram_setting    = ram_next;
        res_next.phase_out      = phase_next;
        res_next.line_count_out = line_next;
        res_next.query_colour   = (beat.query_pen <= vgarq_pkg::BORDER_PEN)
                                  ? ink_next[beat.query_pen] : 5'd0;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (beat_take)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plus_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            plus_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            line_reg      <= '0;
            resync_reg    <= '0;
            hs_last_reg   <= 1'b0;
            vs_last_reg   <= 1'b0;
            irq_reg       <= 1'b0;
            pen_reg       <= '0;
            cur_mode_reg  <= vgarq_pkg::MODE_RESET;
            want_mode_reg <= vgarq_pkg::MODE_RESET;
            rom_reg       <= '0;
            ram_reg       <= '0;
            for (int i = 0; i < vgarq_pkg::PEN_COUNT; i++)
            begin
                ink_reg[i] <= '0;
            end
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (beat_take)
            begin
                phase_reg     <= phase_next;
                line_reg      <= line_next;
                resync_reg    <= resync_next;
                hs_last_reg   <= beat.hsync_level;
                vs_last_reg   <= beat.vsync_level;
                irq_reg       <= irq_next;
                pen_reg       <= pen_next;
                cur_mode_reg  <= cur_mode_next;
                want_mode_reg <= want_mode_next;
                rom_reg       <= rom_next;
                ram_reg       <= ram_next;
                for (int i = 0; i < vgarq_pkg::PEN_COUNT; i++)
                begin
                    ink_reg[i] <= ink_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (beat_take)
        begin
            res_reg <= res_next;
        end
    end

endmodule

### src/video_gate_array_raster_irq.sv
// Channel   Handshake              Payload
// input     in_valid / in_ready    hsync_level .. query_pen, one tick per beat
// output    out_valid / out_ready  irq_out .. query_colour, one beat per input
// config    cfg_we                 cfg_wdata (plus_attached)
//
// One beat per cycle sustained while out_ready holds; a result passes through the
// input register, then the result register, before it is on the outputs.
// The input register keeps taking beats while a result waits, until both fill.
// rst_n clears all state: mode 1, counters, palette and banking bytes to 0.
module video_gate_array_raster_irq
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        hsync_level,
    input  logic        vsync_level,
    input  logic        cpu_m1,
    input  logic        cpu_iorq,
    input  logic        cpu_wr,
    input  logic [15:0] cpu_address,
    input  logic [7:0]  cpu_data,
    input  logic        companion_unlocked,
    input  logic        companion_irq_active,
    input  logic [4:0]  query_pen,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        irq_out,
    output logic [1:0]  active_mode,
    output logic [7:0]  rom_setting,
    output logic [7:0]  ram_setting,
    output logic [3:0]  phase_out,
    output logic [5:0]  line_count_out,
    output logic [4:0]  query_colour
);

    vgarq_pkg::in_beat_t  in_beat;
    vgarq_pkg::in_beat_t  beat;
    vgarq_pkg::out_beat_t res;
    logic                 beat_valid;
    logic                 beat_take;

    always_comb
    begin
        in_beat.hsync_level          = hsync_level;
        in_beat.vsync_level          = vsync_level;
        in_beat.cpu_m1               = cpu_m1;
        in_beat.cpu_iorq             = cpu_iorq;
        in_beat.cpu_wr               = cpu_wr;
        in_beat.cpu_address          = cpu_address;
        in_beat.cpu_data             = cpu_data;
        in_beat.companion_unlocked   = companion_unlocked;
        in_beat.companion_irq_active = companion_irq_active;
        in_beat.query_pen            = query_pen;
    end

    vgarq_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take)
    );

    vgarq_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .beat_valid (beat_valid),
        .beat       (beat),
        .beat_take  (beat_take),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign irq_out        = res.irq_out;
    assign active_mode    = res.active_mode;
    assign rom_setting    = res.rom_setting;
    assign ram_setting    = res.ram_setting;
    assign phase_out      = res.phase_out;
    assign line_count_out = res.line_count_out;
    assign query_colour   = res.query_colour;

`ifndef ASSERT_OFF
    // counter wraps on reaching the interrupt line, so it never shows it
    a_line_below_irq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (line_count_out < vgarq_pkg::RASTER_INT_LINE))
        else $error("line counter reached interrupt line");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    a_beat_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (beat_valid && !out_valid) |=> out_valid)
        else $error("buffered beat did not reach result register");
`endif

endmodule

### tb/sv/video_gate_array_raster_irq_tb.sv
module video_gate_array_raster_irq_tb;

    localparam int HOLD_CYCLES = 40;

    // Mirror of the gate array: sync edges, line counter, palette, banking bytes.
    class raster_scoreboard;
        logic       plus_attached;
        logic [3:0] phase;
        logic [5:0] lines;
        logic [1:0] resync;
        logic       hs_prev;
        logic       vs_prev;
        logic       irq;
        logic [4:0] pen;
        logic [1:0] mode_now;
        logic [1:0] mode_next;
        logic [7:0] rom_byte;
        logic [7:0] ram_byte;
        logic [4:0] inks [vgarq_pkg::PEN_COUNT];
        vgarq_pkg::out_beat_t expected_beats [$];
        int         errors;

        function new();
            errors = 0;
            plus_attached = 1'b0;
            phase = '0;
            lines = '0;
            resync = '0;
            hs_prev = 1'b0;
            vs_prev = 1'b0;
            irq = 1'b0;
            pen = '0;
            mode_now = vgarq_pkg::MODE_RESET;
            mode_next = vgarq_pkg::MODE_RESET;
            rom_byte = '0;
            ram_byte = '0;
            foreach (inks[i])
                inks[i] = '0;
        endfunction

        function void count_line(logic owns);
            lines = lines + 6'd1;
            if (lines == vgarq_pkg::RASTER_INT_LINE)
            begin
                if (owns)
                    irq = 1'b1;
                lines = '0;
            end
            if (resync != 0)
            begin
                resync = resync - 2'd1;
                if (resync == 0)
                begin
                    if (lines >= vgarq_pkg::RESYNC_MARGIN && owns)
                        irq = 1'b1;
                    lines = '0;
                end
            end
        endfunction

        function void port_write(logic [7:0] d, logic unlocked);
            case (vgarq_pkg::port_fn_t'(d[7:6]))
                vgarq_pkg::FN_PEN:
                    pen = d[4] ? vgarq_pkg::BORDER_PEN : {1'b0, d[3:0]};
                vgarq_pkg::FN_INK:
                    if (pen <= vgarq_pkg::BORDER_PEN)
                        inks[pen] = d[4:0];
                vgarq_pkg::FN_MODE:
                    // remap form belongs to the companion chip
                    if (!(plus_attached && unlocked && d[5]))
                    begin
                        mode_next = d[1:0];
                        rom_byte = d;
                        if (d[4])
                        begin
                            irq = 1'b0;
                            lines = '0;
                        end
                    end
                default:
                    ram_byte = d;
            endcase
        endfunction

        function void take_tick(vgarq_pkg::in_beat_t b);
            logic      hs_rise;
            logic      hs_fall;
            logic      vs_rise;
            vgarq_pkg::out_beat_t e;
            phase = phase + 4'd1;
            hs_rise = b.hsync_level && !hs_prev;
            hs_fall = !b.hsync_level && hs_prev;
            vs_rise = b.vsync_level && !vs_prev;
            hs_prev = b.hsync_level;
            vs_prev = b.vsync_level;
            if (hs_rise)
                mode_now = mode_next;
            if (vs_rise)
                resync = vgarq_pkg::RESYNC_LINES;
            if (hs_fall)
                count_line(!(plus_attached && b.companion_irq_active));
            // acknowledge lands before any port write in the same tick
            if (b.cpu_m1 && b.cpu_iorq)
            begin
                lines[5] = 1'b0;
                irq = 1'b0;
            end
            if (b.cpu_iorq && b.cpu_wr && b.cpu_address[15:14] == vgarq_pkg::PORT_SELECT)
                port_write(b.cpu_data, b.companion_unlocked);
            e.irq_out = irq;
            e.active_mode = mode_now;
            e.rom_setting = rom_byte;
            e.ram_setting = ram_byte;
            e.phase_out = phase;
            e.line_count_out = lines;
            e.query_colour = (b.query_pen <= vgarq_pkg::BORDER_PEN) ? inks[b.query_pen] : '0;
            expected_beats.push_back(e);
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("mismatch %s: got %0h want %0h", what, got, want);
        endtask

        task check_beat(vgarq_pkg::out_beat_t r);
            vgarq_pkg::out_beat_t e;
            if (expected_beats.size() == 0)
            begin
                report_mismatch("unexpected result beat", 0, 0);
                return;
            end
            e = expected_beats.pop_front();
            if (r.irq_out !== e.irq_out)
                report_mismatch("irq_out", r.irq_out, e.irq_out);
            if (r.active_mode !== e.active_mode)
                report_mismatch("active_mode", r.active_mode, e.active_mode);
            if (r.rom_setting !== e.rom_setting)
                report_mismatch("rom_setting", r.rom_setting, e.rom_setting);
            if (r.ram_setting !== e.ram_setting)
                report_mismatch("ram_setting", r.ram_setting, e.ram_setting);
            if (r.phase_out !== e.phase_out)
                report_mismatch("phase_out", r.phase_out, e.phase_out);
            if (r.line_count_out !== e.line_count_out)
                report_mismatch("line_count_out", r.line_count_out, e.line_count_out);
            if (r.query_colour !== e.query_colour)
                report_mismatch("query_colour", r.query_colour, e.query_colour);
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_wdata = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    vgarq_pkg::in_beat_t tx = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       irq_out;
    logic [1:0] active_mode;
    logic [7:0] rom_setting;
    logic [7:0] ram_setting;
    logic [3:0] phase_out;
    logic [5:0] line_count_out;
    logic [4:0] query_colour;

    raster_scoreboard sb;
    bit  quiet = 1'b0;
    bit  hold_off = 1'b0;
    bit  hs_lvl = 1'b0;
    int  hs_hold = 0;
    int  vs_hold = 0;

    video_gate_array_raster_irq dut
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cfg_we               (cfg_we),
        .cfg_wdata            (cfg_wdata),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .hsync_level          (tx.hsync_level),
        .vsync_level          (tx.vsync_level),
        .cpu_m1               (tx.cpu_m1),
        .cpu_iorq             (tx.cpu_iorq),
        .cpu_wr               (tx.cpu_wr),
        .cpu_address          (tx.cpu_address),
        .cpu_data             (tx.cpu_data),
        .companion_unlocked   (tx.companion_unlocked),
        .companion_irq_active (tx.companion_irq_active),
        .query_pen            (tx.query_pen),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .irq_out              (irq_out),
        .active_mode          (active_mode),
        .rom_setting          (rom_setting),
        .ram_setting          (ram_setting),
        .phase_out            (phase_out),
        .line_count_out       (line_count_out),
        .query_colour         (query_colour)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.take_tick(tx);
            if (out_valid && out_ready)
                sb.check_beat({irq_out, active_mode, rom_setting, ram_setting,
                               phase_out, line_count_out, query_colour});
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always
    begin
        @(posedge clk);
        if (hold_off)
        begin
            hold_off = 1'b0;
            out_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        else
            out_ready <= 1'b1;
    end

    task automatic send_beat(input vgarq_pkg::in_beat_t b);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        tx <= b;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        // let the beat taken at this edge reach the scoreboard first
        @(posedge clk);
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_plus(input logic v);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.plus_attached = v;
    endtask

    function automatic vgarq_pkg::in_beat_t port_beat(input logic [7:0] d,
                                                      input logic [15:0] a,
                                                      input logic [4:0] qp);
        vgarq_pkg::in_beat_t b;
        b = '0;
        b.cpu_iorq = 1'b1;
        b.cpu_wr = 1'b1;
        b.cpu_address = a;
        b.cpu_data = d;
        b.query_pen = qp;
        return b;
    endfunction

    // Sync waveform runs continuously; CPU traffic is mostly well-formed.
    function automatic vgarq_pkg::in_beat_t next_tick();
        vgarq_pkg::in_beat_t b;
        int       kind;
        b = '0;
        if (hs_hold == 0)
        begin
            hs_lvl = !hs_lvl;
            hs_hold = $urandom_range(1, 2);
        end
        hs_hold--;
        if (vs_hold == 0 && $urandom_range(0, 299) == 0)
            vs_hold = $urandom_range(2, 12);
        b.hsync_level = hs_lvl;
        b.vsync_level = (vs_hold != 0);
        if (vs_hold != 0)
            vs_hold--;
        b.cpu_address = 16'($urandom);
        b.cpu_data = 8'($urandom);
        b.companion_unlocked = 1'($urandom_range(0, 1));
        b.companion_irq_active = 1'($urandom_range(0, 1));
        b.query_pen = 5'($urandom_range(0, 31));
        b.cpu_m1 = 1'($urandom_range(0, 1));
        b.cpu_wr = 1'($urandom_range(0, 1));
        kind = $urandom_range(0, 99);
        if (sb.irq && $urandom_range(0, 15) == 0)
        begin
            b.cpu_m1 = 1'b1;
            b.cpu_iorq = 1'b1;
        end
        else if (kind < 1)
        begin
            b.cpu_m1 = 1'b1;
            b.cpu_iorq = 1'b1;
        end
        else if (kind < 9)
        begin
            b.cpu_m1 = 1'b0;
            b.cpu_iorq = 1'b1;
            b.cpu_wr = 1'b1;
            b.cpu_address[15:14] = vgarq_pkg::PORT_SELECT;
            // keep rearms rare so the counter can reach line 52
            if (b.cpu_data[7:6] == vgarq_pkg::FN_MODE && $urandom_range(0, 7) != 0)
                b.cpu_data[4] = 1'b0;
        end
        else if (kind < 11)
            b.cpu_iorq = 1'b1;
        else
            b.cpu_iorq = 1'b0;
        return b;
    endfunction

    task automatic random_phase(input int count, input int pause_at, input int hold_at);
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_off = 1'b1;
            if (i == pause_at)
                drain();
            send_beat(next_tick());
        end
    endtask

    initial
    begin
        #2000000;
        $display("video_gate_array_raster_irq_tb NOT OK");
        $finish;
    end

    initial
    begin
        vgarq_pkg::in_beat_t b;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_plus(1'b0);

        b = '0;
        send_beat(b);
        // every strobe high but no io request; bad pen readback
        b = '1;
        b.cpu_iorq = 1'b0;
        b.query_pen = 5'd31;
        send_beat(b);
        send_beat(port_beat({vgarq_pkg::FN_PEN, 6'h10}, 16'h4000, vgarq_pkg::BORDER_PEN));
        send_beat(port_beat({vgarq_pkg::FN_INK, 6'h1F}, 16'h7FFF, vgarq_pkg::BORDER_PEN));
        send_beat(port_beat({vgarq_pkg::FN_PEN, 6'h0F}, 16'h4000, 5'd15));
        send_beat(port_beat({vgarq_pkg::FN_INK, 6'h20}, 16'h4000, 5'd15));
        send_beat(port_beat({vgarq_pkg::FN_PEN, 6'h00}, 16'h4000, 5'd0));
        send_beat(port_beat({vgarq_pkg::FN_INK, 6'h3F}, 16'h4000, 5'd0));
        send_beat(port_beat({vgarq_pkg::FN_MODE, 6'h03}, 16'h4000, 5'd0));
        b = '0;
        b.hsync_level = 1'b1;
        send_beat(b);
        b.hsync_level = 1'b0;
        send_beat(b);
        send_beat(port_beat({vgarq_pkg::FN_MODE, 6'h1C}, 16'h4000, 5'd0));
        send_beat(port_beat({vgarq_pkg::FN_RAM, 6'h3F}, 16'h4000, 5'd0));
        send_beat(port_beat({vgarq_pkg::FN_RAM, 6'h00}, 16'h7FFF, 5'd0));
        // address outside the block's window
        send_beat(port_beat({vgarq_pkg::FN_RAM, 6'h15}, 16'hC000, 5'd0));
        send_beat(port_beat({vgarq_pkg::FN_RAM, 6'h15}, 16'h8000, 5'd0));
        send_beat(port_beat({vgarq_pkg::FN_RAM, 6'h15}, 16'h3FFF, 5'd0));
        // acknowledge together with a write
        b = port_beat({vgarq_pkg::FN_RAM, 6'h05}, 16'h4000, 5'd0);
        b.cpu_m1 = 1'b1;
        send_beat(b);
        b = '0;
        b.cpu_m1 = 1'b1;
        b.cpu_iorq = 1'b1;
        send_beat(b);
        b = port_beat({vgarq_pkg::FN_MODE, 6'h22}, 16'h4000, 5'd17);
        b.companion_unlocked = 1'b1;
        send_beat(b);
        drain();

        write_plus(1'b1);
        b = port_beat({vgarq_pkg::FN_MODE, 6'h31}, 16'h4000, vgarq_pkg::BORDER_PEN);
        b.companion_unlocked = 1'b1;
        send_beat(b);
        b.companion_unlocked = 1'b0;
        send_beat(b);
        b = '0;
        b.companion_irq_active = 1'b1;
        b.hsync_level = 1'b1;
        send_beat(b);
        b.hsync_level = 1'b0;
        send_beat(b);
        drain();

        write_plus(1'b0);
        random_phase(400, -1, 100);
        drain();
        write_plus(1'b1);
        random_phase(400, 200, -1);
        drain();
        write_plus(1'b0);
        random_phase(300, -1, -1);
        drain();
        write_plus(1'b1);
        quiet = 1'b1;
        random_phase(300, -1, -1);
        drain();
        repeat (4) @(posedge clk);

        if (sb.errors == 0 && sb.expected_beats.size() == 0)
            $display("video_gate_array_raster_irq_tb OK");
        else
            $display("video_gate_array_raster_irq_tb NOT OK");
        $finish;
    end

endmodule
